// File: hw/rtl/acc_cpu_pkg.sv
// ----------------------------------------------------------------------------
// acc_cpu_pkg
// shared types and constants of the accumulator cpu execute block
// ----------------------------------------------------------------------------
package acc_cpu_pkg;

  localparam int DATA_WORDS = 4096;
  localparam int ADDR_W     = $clog2(DATA_WORDS);
  localparam int WORD_W     = 32;
  localparam int IMM_W      = 24;
  localparam int OPC_W      = 8;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 136;

  typedef enum logic [OPC_W-1:0] {
    OP_LDC  = 8'd0,
    OP_ADC  = 8'd1,
    OP_LDL  = 8'd2,
    OP_STL  = 8'd3,
    OP_LDNL = 8'd4,
    OP_STNL = 8'd5,
    OP_ADD  = 8'd6,
    OP_SUB  = 8'd7,
    OP_SHL  = 8'd8,
    OP_SHR  = 8'd9,
    OP_ADJ  = 8'd10,
    OP_A2SP = 8'd11,
    OP_SP2A = 8'd12,
    OP_CALL = 8'd13,
    OP_RET  = 8'd14,
    OP_BRZ  = 8'd15,
    OP_BRLZ = 8'd16,
    OP_BR   = 8'd17,
    OP_HALT = 8'd18
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_ILL  = 2'd2
  } stop_t;

  typedef struct packed {
    stop_t             stop;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] sp;
    logic [WORD_W-1:0] pc;
  } arch_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

// File: hw/rtl/acc_cpu_ram.sv
// ----------------------------------------------------------------------------
// acc_cpu_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module acc_cpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/acc_cpu_alu.sv
// ----------------------------------------------------------------------------
// acc_cpu_alu
// next architectural state and data memory write for one instruction
// ----------------------------------------------------------------------------
module acc_cpu_alu (
  input  logic [acc_cpu_pkg::OPC_W-1:0]  opcode,
  input  logic [acc_cpu_pkg::IMM_W-1:0]  imm,
  input  acc_cpu_pkg::arch_t             cur,
  input  logic [acc_cpu_pkg::WORD_W-1:0] rdata,
  output acc_cpu_pkg::arch_t             nxt,
  output acc_cpu_pkg::mem_wr_t           mw
);
  import acc_cpu_pkg::*;

  logic [WORD_W-1:0] imm_x;
  logic [WORD_W-1:0] pc1;
  logic [WORD_W-1:0] sp_sum;
  logic [WORD_W-1:0] a_sum;

  assign imm_x  = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
  assign pc1    = cur.pc + 32'd1;
  assign sp_sum = cur.sp + imm_x;
  assign a_sum  = cur.a + imm_x;

  always_comb begin
    nxt     = cur;
    mw.we   = 1'b0;
    mw.addr = sp_sum[ADDR_W-1:0];
    mw.data = cur.a;
    if (cur.stop == ST_RUN) begin
      nxt.pc = pc1;
      case (opcode)
        OP_LDC: begin
          nxt.b = cur.a;
          nxt.a = imm_x;
        end
        OP_ADC: nxt.a = a_sum;
        OP_LDL: begin
          nxt.b = cur.a;
          nxt.a = rdata;
        end
        OP_STL: begin
          mw.we = 1'b1;
          nxt.a = cur.b;
        end
        OP_LDNL: nxt.a = rdata;
        OP_STNL: begin
          mw.we   = 1'b1;
          mw.addr = a_sum[ADDR_W-1:0];
          mw.data = cur.b;
        end
        OP_ADD: nxt.a = cur.a + cur.b;
        OP_SUB: nxt.a = cur.b - cur.a;
        OP_SHL: nxt.a = cur.b << cur.a[4:0];
        OP_SHR: nxt.a = $unsigned($signed(cur.b) >>> cur.a[4:0]);
        OP_ADJ: nxt.sp = sp_sum;
        OP_A2SP: begin
          nxt.sp = cur.a;
          nxt.a  = cur.b;
        end
        OP_SP2A: begin
          nxt.b = cur.a;
          nxt.a = cur.sp;
        end
        OP_CALL: begin
          nxt.b  = cur.a;
          nxt.a  = pc1;
          nxt.pc = pc1 + imm_x;
        end
        OP_RET: begin
          nxt.pc = cur.a;
          nxt.a  = cur.b;
        end
        OP_BRZ: begin
          if (cur.a == '0) begin
            nxt.pc = pc1 + imm_x;
          end
        end
        OP_BRLZ: begin
          if (cur.a[WORD_W-1]) begin
            nxt.pc = pc1 + imm_x;
          end
        end
        OP_BR: nxt.pc = pc1 + imm_x;
        OP_HALT: nxt.stop = ST_HALT;
        default: nxt.stop = ST_ILL;
      endcase
    end
  end

endmodule

// File: hw/rtl/acc_cpu_outq.sv
// ----------------------------------------------------------------------------
// acc_cpu_outq
// two entry result queue in front of the output channel
// ----------------------------------------------------------------------------
module acc_cpu_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  acc_cpu_pkg::arch_t             push_data,
  output logic                           full,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acc_cpu_pkg::OUT_W-1:0]  out_tdata
);
  import acc_cpu_pkg::*;

  arch_t      q_r [2];
  logic       head_r;
  logic       tail_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign out_tdata  = {{(OUT_W-$bits(arch_t)){1'b0}}, q_r[head_r]};

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        tail_r <= ~tail_r;
      end
      if (pop) begin
        head_r <= ~head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/accumulator_cpu_execute.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// execute stage of a two register accumulator machine with word data memory
// ----------------------------------------------------------------------------
// in_* carries one instruction per item: opcode and 24-bit immediate.
// out_* returns one item per instruction: pc, sp, a, b and status after it.
// the next instruction to feed is the one at the pc of the last result.
// an accepted item issues its data memory read in the same cycle; in the
// cycle after, the read word is back, registers update, stores are written
// and the result enters a two entry output queue. in_tready stays low while
// an item is in execute, since every load needs the registered ram read
// before the following instruction can form its address; the next item is
// taken once that result is in and the output queue has room.
// after reset the data memory is cleared one word per cycle with in_tready
// low. a stalled receiver fills the output queue; in_tready drops while it
// is full and no result is lost.
// halt and illegal opcodes stop the machine: later items return the same
// state and status.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [acc_cpu_pkg::OPC_W-1:0] in_tuser,   // req_type
  input  logic [acc_cpu_pkg::IN_W-1:0]  in_tdata,   // immediate
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [acc_cpu_pkg::OUT_W-1:0] out_tdata   // pc_out, sp_out, acc_a, acc_b, status
);
  import acc_cpu_pkg::*;

  arch_t               st_r;
  arch_t               st_nxt;
  mem_wr_t             alu_wr;
  logic                ex_v_r;
  logic [OPC_W-1:0]    ex_op_r;
  logic [IMM_W-1:0]    ex_imm_r;
  logic [ADDR_W:0]     clr_cnt_r;
  logic                clr_done;
  logic                q_full;
  logic                accept;
  logic [OPC_W-1:0]    in_op;
  logic [IMM_W-1:0]    in_imm;
  logic [WORD_W-1:0]   rd_base;
  logic [WORD_W-1:0]   rd_sum;
  logic [WORD_W-1:0]   rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  assign clr_done  = clr_cnt_r[ADDR_W];
  assign in_tready = clr_done && !ex_v_r && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_imm    = in_tdata[IMM_W-1:0];

  // load address from the registers as they stand at acceptance
  assign rd_base = (op_t'(in_op) == OP_LDNL) ? st_r.a : st_r.sp;
  assign rd_sum  = rd_base + {{(WORD_W-IMM_W){in_imm[IMM_W-1]}}, in_imm};

  assign ram_we    = clr_done ? (ex_v_r && alu_wr.we) : 1'b1;
  assign ram_waddr = clr_done ? alu_wr.addr : clr_cnt_r[ADDR_W-1:0];
  assign ram_wdata = clr_done ? alu_wr.data : '0;

  acc_cpu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_sum[ADDR_W-1:0]),
    .rdata (rdata)
  );

  acc_cpu_alu u_alu (
    .opcode (ex_op_r),
    .imm    (ex_imm_r),
    .cur    (st_r),
    .rdata  (rdata),
    .nxt    (st_nxt),
    .mw     (alu_wr)
  );

  acc_cpu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ex_v_r),
    .push_data  (st_nxt),
    .full       (q_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{stop: ST_RUN, default: '0};
      ex_v_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      ex_v_r <= accept;
      if (ex_v_r) begin
        st_r <= st_nxt;
      end
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_op_r  <= in_op;
      ex_imm_r <= in_imm;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !in_tready)
    else $error("item accepted during memory clear");

  a_ex_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ex_v_r && !in_tready)
    else $error("accepted item did not enter execute");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.stop != ST_RUN) |=> (st_r.stop == $past(st_r.stop)))
    else $error("stop code changed after stop");

  a_no_store_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_v_r && st_r.stop != ST_RUN) |-> !ram_we)
    else $error("memory written while stopped");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the accumulator cpu execute stage
// ----------------------------------------------------------------------------
// instructions are streamed in, and a scoreboard predicts pc, sp, a, b and
// status for each one from its own copy of the machine state. a directed
// opening walks every opcode but halt, both immediate extremes, address wrap,
// shift counts from the low bits of a, and taken and untaken branches. then
// random instructions run with random idling on both sides, one calm stretch
// and one long receiver stall. a stop opcode tail closes the run.
// ----------------------------------------------------------------------------
module tb;
  import acc_cpu_pkg::*;

  class acc_scoreboard;
    logic [WORD_W-1:0] pc, sp, a, b;
    stop_t             stop;
    logic [WORD_W-1:0] dmem [DATA_WORDS];
    arch_t             expected_q [$];
    int                errors;
    int                n_checked;

    function new();
      pc = '0;
      sp = '0;
      a = '0;
      b = '0;
      stop = ST_RUN;
      foreach (dmem[i]) dmem[i] = '0;
      errors = 0;
      n_checked = 0;
    endfunction

    // power of two depth: signed modulo equals the low address bits
    function logic [ADDR_W-1:0] word_index(logic [WORD_W-1:0] base, logic [WORD_W-1:0] ofs);
      logic [WORD_W-1:0] sum;
      sum = base + ofs;
      return sum[ADDR_W-1:0];
    endfunction

    function void note_instr(logic [OPC_W-1:0] op, logic [IMM_W-1:0] imm);
      logic [WORD_W-1:0] simm;
      arch_t             exp;
      simm = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
      if (stop == ST_RUN) begin
        pc = pc + 1;
        case (op)
          OP_LDC: begin
            b = a;
            a = simm;
          end
          OP_ADC: a = a + simm;
          OP_LDL: begin
            b = a;
            a = dmem[word_index(sp, simm)];
          end
          OP_STL: begin
            dmem[word_index(sp, simm)] = a;
            a = b;
          end
          OP_LDNL: a = dmem[word_index(a, simm)];
          OP_STNL: dmem[word_index(a, simm)] = b;
          OP_ADD: a = a + b;
          OP_SUB: a = b - a;
          OP_SHL: a = b << a[4:0];
          OP_SHR: a = $signed(b) >>> a[4:0];
          OP_ADJ: sp = sp + simm;
          OP_A2SP: begin
            sp = a;
            a = b;
          end
          OP_SP2A: begin
            b = a;
            a = sp;
          end
          OP_CALL: begin
            b = a;
            a = pc;
            pc = pc + simm;
          end
          OP_RET: begin
            pc = a;
            a = b;
          end
          OP_BRZ: if (a == '0) pc = pc + simm;
          OP_BRLZ: if (a[WORD_W-1]) pc = pc + simm;
          OP_BR: pc = pc + simm;
          OP_HALT: stop = ST_HALT;
          default: stop = ST_ILL;
        endcase
      end
      exp.pc = pc;
      exp.sp = sp;
      exp.a = a;
      exp.b = b;
      exp.stop = stop;
      expected_q.insert(expected_q.size(), exp);
    endfunction

    function void compare(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
      if (exp !== act) begin
        $display("%0t %s mismatch: expected %h actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      arch_t got;
      arch_t exp;
      got = arch_t'(data[$bits(arch_t)-1:0]);
      n_checked++;
      if (expected_q.size() == 0) begin
        $display("%0t result with no instruction pending: expected none actual %h", $time, data);
        errors++;
      end else begin
        exp = expected_q.pop_front();
        compare("pc", exp.pc, got.pc);
        compare("sp", exp.sp, got.sp);
        compare("a", exp.a, got.a);
        compare("b", exp.b, got.b);
        compare("status", WORD_W'(exp.stop), WORD_W'(got.stop));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OPC_W-1:0] in_tuser = '0;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic             calm = 1'b0;
  logic             long_hold_done = 1'b0;
  acc_scoreboard    sb;

  accumulator_cpu_execute i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_instr(input logic [OPC_W-1:0] op, input logic [IMM_W-1:0] imm);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= imm;
    do @(posedge clk); while (!in_tready);
    sb.note_instr(op, imm);
    @(negedge clk);
  endtask

  function automatic logic [IMM_W-1:0] pick_imm();
    case ($urandom_range(0, 4))
      0: return IMM_W'($urandom_range(0, 31)) - IMM_W'(16);
      1: return 24'h7fffff;
      2: return 24'h800000;
      default: return IMM_W'($urandom);
    endcase
  endfunction

  // receiver: random stalls plus one long hold that backs up the block
  always begin
    @(negedge clk);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!long_hold_done && sb.n_checked >= 120) begin
      out_tready <= 1'b0;
      repeat (100) @(negedge clk);
      long_hold_done = 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // immediate extremes and arithmetic
    send_instr(OP_LDC, 24'h7fffff);
    send_instr(OP_LDC, 24'h800000);
    send_instr(OP_ADC, 24'h7fffff);
    send_instr(OP_ADD, 24'h000000);
    send_instr(OP_SUB, 24'hffffff);
    // shift count from the low five bits of a
    send_instr(OP_LDC, 24'd37);
    send_instr(OP_SHL, 24'd0);
    send_instr(OP_LDC, -24'd100);
    send_instr(OP_LDC, 24'd35);
    send_instr(OP_SHR, 24'd0);
    // negative sp and addresses that wrap
    send_instr(OP_ADJ, -24'd5);
    send_instr(OP_STL, 24'd2);
    send_instr(OP_LDL, 24'd2);
    send_instr(OP_LDL, 24'h7fffff);
    send_instr(OP_LDC, 24'd100);
    send_instr(OP_STNL, -24'd1);
    send_instr(OP_LDNL, -24'd1);
    send_instr(OP_SP2A, 24'd0);
    send_instr(OP_A2SP, 24'd0);
    send_instr(OP_CALL, 24'd5);
    send_instr(OP_RET, 24'd0);
    // branches taken and not taken
    send_instr(OP_LDC, 24'd0);
    send_instr(OP_BRZ, 24'd4);
    send_instr(OP_BRLZ, 24'd4);
    send_instr(OP_ADC, -24'd1);
    send_instr(OP_BRLZ, -24'd3);
    send_instr(OP_BRZ, 24'd9);
    send_instr(OP_BR, 24'h800000);

    for (int n = 0; n < 500; n++) begin
      calm = (n >= 300 && n < 380);
      send_instr(OPC_W'($urandom_range(OP_LDC, OP_BR)), pick_imm());
    end
    calm = 1'b0;

    // stop opcodes are sticky, so they close the run
    send_instr(8'hff, pick_imm());
    send_instr(OP_HALT, 24'd0);
    send_instr(8'h80, pick_imm());
    for (int n = 0; n < 6; n++) send_instr(OPC_W'($urandom_range(0, 255)), pick_imm());
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/acc_cpu_pkg.sv
hw/rtl/acc_cpu_ram.sv
hw/rtl/acc_cpu_alu.sv
hw/rtl/acc_cpu_outq.sv
hw/rtl/accumulator_cpu_execute.sv
tb/tb.sv
